FILE: rtl/rav_pkg.sv
// ============================================================================
// rav_pkg: shared types and constants for the radial acceleration vector
// Field widths, datapath widths, config register codes and pipeline types.
// ============================================================================
package rav_pkg;

    // external field widths
    localparam int POS_W      = 32;
    localparam int ACC_W      = 32;
    localparam int MAG_W      = 32;
    localparam int CENTER_W   = 31;
    localparam int DIM_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // default parameter values
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int DEF_COORD_BITS    = 32;

    // datapath widths
    localparam int DIFF_W    = 34;  // position minus center, exact
    localparam int PRE_SHIFT = 8;   // fixed left shift before the normalizer
    localparam int NORM_W    = 42;  // normalized dx/dy, |v| < 2^41
    localparam int MX_W      = 41;  // normalized max(|dx|,|dy|)
    localparam int NORM_STEPS = 6;  // shift steps 32,16,8,4,2,1
    localparam int VEC_W     = 44;  // vectoring x/y with CORDIC growth
    localparam int ROT_W     = 58;  // rotation x/y, magnitude times 2^24
    localparam int FRAC_DROP = 24;  // final rounding shift

    // gain constant, Q32
    localparam logic [63:0] GAIN_INF = 64'd2608131496;

    // configuration register codes
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_MAG   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_CENTER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS  = 2'd2;

    localparam logic [DIM_W-1:0] DIM_LINE = 2'd1;

    // sideband that travels with each request
    typedef struct packed {
        logic flip;    // dx was negative: vector mirrored, also 1D left side
        logic dim1;    // line geometry
        logic center;  // exact center in 2D
    } t_side;

    // CORDIC cell payload
    typedef struct packed {
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic signed [ROT_W-1:0] rx;
        logic signed [ROT_W-1:0] ry;
    } t_cordic;

    // result item
    typedef struct packed {
        logic signed [ACC_W-1:0] acc_y;
        logic signed [ACC_W-1:0] acc_x;
        logic                    at_center;
    } t_result;

endpackage

FILE: rtl/rav_front.sv
// ============================================================================
// rav_front: offset from center, half-plane fold and magnitude bound
// Two register stages: exact difference, then fold to dx >= 0 and max(|dx|,|dy|).
// ============================================================================
module rav_front #(
    parameter int COORD_BITS = rav_pkg::DEF_COORD_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic signed [rav_pkg::POS_W-1:0]       i_pos_x,
    input  logic signed [rav_pkg::POS_W-1:0]       i_pos_y,
    input  logic        [rav_pkg::CENTER_W-1:0]    i_center,
    input  logic                                   i_dim1,
    output logic                                   o_valid,
    output rav_pkg::t_side                         o_side,
    output logic signed [rav_pkg::NORM_W-1:0]      o_dx,
    output logic signed [rav_pkg::NORM_W-1:0]      o_dy,
    output logic        [rav_pkg::MX_W-1:0]        o_mx
);
    import rav_pkg::*;

    localparam int PosBits = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;

    logic                     r1_valid, r2_valid;
    logic signed [DIFF_W-1:0] r1_dx, r1_dy;
    logic signed [DIFF_W-1:0] r2_dx, r2_dy;
    logic        [DIFF_W-2:0] r2_mx;
    t_side                    r2_side;

    logic signed [DIFF_W-1:0] n_dx, n_dy, ext_x, ext_y, ctr;
    logic signed [DIFF_W-1:0] n_fx, n_fy, ax, ay;
    logic signed [DIFF_W-1:0] n_mx;
    t_side                    n_side;

    always_comb begin
        ext_x = DIFF_W'($signed(i_pos_x[PosBits-1:0]));
        ext_y = DIFF_W'($signed(i_pos_y[PosBits-1:0]));
        ctr   = $signed({{(DIFF_W-CENTER_W){1'b0}}, i_center});
        n_dx  = ext_x - ctr;
        n_dy  = ext_y - ctr;
    end

    always_comb begin
        n_side.flip   = r1_dx[DIFF_W-1];
        n_side.dim1   = i_dim1;
        n_side.center = (r1_dx == '0) && (r1_dy == '0);
        n_fx = n_side.flip ? -r1_dx : r1_dx;
        n_fy = n_side.flip ? -r1_dy : r1_dy;
        ax   = r1_dx[DIFF_W-1] ? -r1_dx : r1_dx;
        ay   = r1_dy[DIFF_W-1] ? -r1_dy : r1_dy;
        n_mx = (ax > ay) ? ax : ay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx   <= n_dx;
            r1_dy   <= n_dy;
            r2_dx   <= n_fx;
            r2_dy   <= n_fy;
            r2_mx   <= n_mx[DIFF_W-2:0];
            r2_side <= n_side;
        end
    end

    assign o_valid = r2_valid;
    assign o_side  = r2_side;
    assign o_dx    = {r2_dx, {PRE_SHIFT{1'b0}}};
    assign o_dy    = {r2_dy, {PRE_SHIFT{1'b0}}};
    assign o_mx    = {r2_mx, {PRE_SHIFT{1'b0}}};

endmodule

FILE: rtl/rav_norm_stage.sv
// ============================================================================
// rav_norm_stage: one step of the normalizing left shift
// Shifts dx/dy by SHIFT when the bound has that many leading zeros.
// ============================================================================
module rav_norm_stage #(
    parameter int SHIFT = 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  rav_pkg::t_side                     i_side,
    input  logic signed [rav_pkg::NORM_W-1:0]  i_dx,
    input  logic signed [rav_pkg::NORM_W-1:0]  i_dy,
    input  logic        [rav_pkg::MX_W-1:0]    i_mx,
    output logic                               o_valid,
    output rav_pkg::t_side                     o_side,
    output logic signed [rav_pkg::NORM_W-1:0]  o_dx,
    output logic signed [rav_pkg::NORM_W-1:0]  o_dy,
    output logic        [rav_pkg::MX_W-1:0]    o_mx
);
    import rav_pkg::*;

    logic                     r_valid;
    t_side                    r_side;
    logic signed [NORM_W-1:0] r_dx, r_dy;
    logic        [MX_W-1:0]   r_mx;
    logic                     do_shift;

    assign do_shift = (i_mx[MX_W-1 -: SHIFT] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_dx   <= do_shift ? (i_dx <<< SHIFT) : i_dx;
            r_dy   <= do_shift ? (i_dy <<< SHIFT) : i_dy;
            r_mx   <= do_shift ? (i_mx << SHIFT) : i_mx;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
    assign o_mx    = r_mx;

endmodule

FILE: rtl/rav_cordic_cell.sv
// ============================================================================
// rav_cordic_cell: one CORDIC micro-rotation, vectoring and rotation paired
// The vectoring decision of step IDX drives the rotation step of the same cell.
// ============================================================================
module rav_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  rav_pkg::t_side   i_side,
    input  rav_pkg::t_cordic i_d,
    output logic             o_valid,
    output rav_pkg::t_side   o_side,
    output rav_pkg::t_cordic o_d
);
    import rav_pkg::*;

    logic                    r_valid;
    t_side                   r_side;
    t_cordic                 r_d;
    t_cordic                 n_d;
    logic signed [VEC_W-1:0] vx, vy, vxs, vys;
    logic signed [ROT_W-1:0] rx, ry, rxs, rys;
    logic                    cw;

    always_comb begin
        vx  = i_d.vx;
        vy  = i_d.vy;
        rx  = i_d.rx;
        ry  = i_d.ry;
        vxs = vx >>> IDX;
        vys = vy >>> IDX;
        rxs = rx >>> IDX;
        rys = ry >>> IDX;
        cw  = ~vy[VEC_W-1];
        // rotation undoes the vectoring sense
        if (cw) begin
            n_d.vx = vx + vys;
            n_d.vy = vy - vxs;
            n_d.rx = rx - rys;
            n_d.ry = ry + rxs;
        end else begin
            n_d.vx = vx - vys;
            n_d.vy = vy + vxs;
            n_d.rx = rx + rys;
            n_d.ry = ry - rxs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_d    <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_d     = r_d;

endmodule

FILE: rtl/rav_out_skid.sv
// ============================================================================
// rav_out_skid: rounding, saturation, special cases and output skid buffer
// Output register plus one skid entry; upstream stalls only when skid is full.
// ============================================================================
module rav_out_skid (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  rav_pkg::t_side                    i_side,
    input  logic signed [rav_pkg::ROT_W-1:0]  i_rx,
    input  logic signed [rav_pkg::ROT_W-1:0]  i_ry,
    input  logic signed [rav_pkg::MAG_W-1:0]  i_mag,
    input  logic                              i_m_ready,
    output logic                              o_ready,
    output logic                              o_valid,
    output rav_pkg::t_result                  o_result
);
    import rav_pkg::*;

    localparam int QW = ROT_W - FRAC_DROP;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    t_result n_res;
    logic    take;

    function automatic logic signed [ACC_W-1:0] round_sat(
        input logic signed [ROT_W-1:0] v,
        input logic                    neg
    );
        logic signed [ROT_W-1:0] a, b, s;
        logic signed [QW-1:0]    q;
        logic                    ovf;
        // -v + half == ~v + 1 + half
        a   = neg ? ~v : v;
        b   = neg ? ROT_W'((64'd1 << (FRAC_DROP - 1)) + 64'd1)
                  : ROT_W'(64'd1 << (FRAC_DROP - 1));
        s   = a + b;
        q   = s[ROT_W-1:FRAC_DROP];
        ovf = (q[QW-1:ACC_W-1] != '0) && (q[QW-1:ACC_W-1] != '1);
        if (ovf) begin
            round_sat = q[QW-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            round_sat = q[ACC_W-1:0];
        end
    endfunction

    always_comb begin
        n_res.acc_x     = '0;
        n_res.acc_y     = '0;
        n_res.at_center = 1'b0;
        if (i_side.dim1) begin
            // left of center: negated magnitude, most negative saturates
            if (!i_side.flip) begin
                n_res.acc_x = i_mag;
            end else if (i_mag == {1'b1, {(MAG_W-1){1'b0}}}) begin
                n_res.acc_x = {1'b0, {(ACC_W-1){1'b1}}};
            end else begin
                n_res.acc_x = -i_mag;
            end
        end else if (i_side.center) begin
            n_res.at_center = 1'b1;
        end else begin
            n_res.acc_x = round_sat(i_rx, i_side.flip);
            n_res.acc_y = round_sat(i_ry, i_side.flip);
        end
    end

    assign take    = r_out_valid & i_m_ready;
    assign o_ready = ~r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_skid_valid) begin
            if (!r_out_valid || take) begin
                r_out_valid <= i_valid;
            end else if (i_valid) begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            if (!r_out_valid || take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end else if (take) begin
            r_out <= r_skid;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: rtl/radial_acceleration_vector_top.sv
// ============================================================================
// radial_acceleration_vector_top: outward acceleration per grid cell
// Streaming pipeline: offset, normalize, CORDIC cell chain, round and skid.
// ============================================================================
// One request carries a cell position (Q16.16) and yields one acceleration
// vector. In line mode (dimensions == 1) acc_x is -magnitude left of the box
// center and +magnitude otherwise, acc_y is zero. In all other modes the
// result is magnitude times the unit vector from the center to the cell,
// found by CORDIC vectoring of (dx,dy) while the gain-compensated magnitude
// is rotated by the same decisions; a cell exactly at the center gives a zero
// vector with at_center set. The pipeline accepts one request per clock while
// the skid is free; its stages are two offset/fold stages, six normalizer
// steps, one CORDIC cell per stage and the rounding register. The
// output has a one-entry skid buffer: when an output request is held off in
// a cycle where the next result arrives, that result parks in the skid and
// the input stalls from the following cycle until the output is taken.
// Configuration writes are always taken and must only be issued while no
// request is in flight; a magnitude write reaches the rotation seed through
// the magnitude register and then the registered seed product.
// ============================================================================
module radial_acceleration_vector_top #(
    parameter int CORDIC_STAGES = rav_pkg::DEF_CORDIC_STAGES,
    parameter int COORD_BITS    = rav_pkg::DEF_COORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream; tdata: pos_x [31:0], pos_y [63:32]
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [2*rav_pkg::POS_W-1:0]         i_s_axis_tdata,
    // output stream; tdata: acc_x [31:0], acc_y [63:32]
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [2*rav_pkg::ACC_W-1:0]         o_m_axis_tdata,
    // tuser: at_center [0]
    output logic                                o_m_axis_tuser,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rav_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rav_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import rav_pkg::*;

    // rotation seed gain: KINF plus the finite-stage correction
    localparam logic [63:0] GainCorr = (GAIN_INF * 64'd2) / 64'd3;
    localparam logic [31:0] GainQ    = 32'(GAIN_INF + (GainCorr >> (2 * CORDIC_STAGES)));

    // ---------------------------------------------------------------- config
    logic signed [MAG_W-1:0]    r_mag;
    logic        [CENTER_W-1:0] r_center;
    logic        [DIM_W-1:0]    r_dim;
    logic signed [63:0]         r_seed_prod;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag    <= '0;
            r_center <= CENTER_W'(32768);
            r_dim    <= DIM_W'(2);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ACCEL_MAG:  r_mag    <= i_cfg_data[MAG_W-1:0];
                CFG_BOX_CENTER: r_center <= i_cfg_data[CENTER_W-1:0];
                CFG_DIMENSIONS: r_dim    <= i_cfg_data[DIM_W-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // magnitude * gain, registered; it only follows the config register
    always_ff @(posedge i_clk) begin
        r_seed_prod <= $signed({{32{r_mag[MAG_W-1]}}, r_mag}) * $signed({32'b0, GainQ});
    end

    // ---------------------------------------------------------------- front
    logic                     en;
    logic                     f_valid;
    t_side                    f_side;
    logic signed [NORM_W-1:0] f_dx, f_dy;
    logic        [MX_W-1:0]   f_mx;

    assign o_s_axis_tready = en;

    rav_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_pos_x (i_s_axis_tdata[POS_W-1:0]),
        .i_pos_y (i_s_axis_tdata[2*POS_W-1:POS_W]),
        .i_center(r_center),
        .i_dim1  (r_dim == DIM_LINE),
        .o_valid (f_valid),
        .o_side  (f_side),
        .o_dx    (f_dx),
        .o_dy    (f_dy),
        .o_mx    (f_mx)
    );

    // ---------------------------------------------------------------- normalize
    // shift steps 32,16,8,4,2,1 bring max(|dx|,|dy|) into [2^40, 2^41)
    logic                     nv [NORM_STEPS+1];
    t_side                    ns [NORM_STEPS+1];
    logic signed [NORM_W-1:0] ndx [NORM_STEPS+1];
    logic signed [NORM_W-1:0] ndy [NORM_STEPS+1];
    logic        [MX_W-1:0]   nmx [NORM_STEPS+1];

    assign nv[0]  = f_valid;
    assign ns[0]  = f_side;
    assign ndx[0] = f_dx;
    assign ndy[0] = f_dy;
    assign nmx[0] = f_mx;

    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        rav_norm_stage #(
            .SHIFT(1 << (NORM_STEPS - 1 - j))
        ) u_norm (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(nv[j]),
            .i_side (ns[j]),
            .i_dx   (ndx[j]),
            .i_dy   (ndy[j]),
            .i_mx   (nmx[j]),
            .o_valid(nv[j+1]),
            .o_side (ns[j+1]),
            .o_dx   (ndx[j+1]),
            .o_dy   (ndy[j+1]),
            .o_mx   (nmx[j+1])
        );
    end

    // ---------------------------------------------------------------- CORDIC chain
    logic    cv [CORDIC_STAGES+1];
    t_side   cs [CORDIC_STAGES+1];
    t_cordic cd [CORDIC_STAGES+1];

    // seed: vectoring input from the normalizer, rotation from (mag*K) >> 8
    always_comb begin
        cv[0]    = nv[NORM_STEPS];
        cs[0]    = ns[NORM_STEPS];
        cd[0].vx = VEC_W'(ndx[NORM_STEPS]);
        cd[0].vy = VEC_W'(ndy[NORM_STEPS]);
        cd[0].rx = ROT_W'($signed(r_seed_prod[63:8]));
        cd[0].ry = '0;
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        rav_cordic_cell #(
            .IDX(i)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(cv[i]),
            .i_side (cs[i]),
            .i_d    (cd[i]),
            .o_valid(cv[i+1]),
            .o_side (cs[i+1]),
            .o_d    (cd[i+1])
        );
    end

    // ---------------------------------------------------------------- output
    t_result res;

    rav_out_skid u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (cv[CORDIC_STAGES]),
        .i_side   (cs[CORDIC_STAGES]),
        .i_rx     (cd[CORDIC_STAGES].rx),
        .i_ry     (cd[CORDIC_STAGES].ry),
        .i_mag    (r_mag),
        .i_m_ready(i_m_axis_tready),
        .o_ready  (en),
        .o_valid  (o_m_axis_tvalid),
        .o_result (res)
    );

    assign o_m_axis_tdata = {res.acc_y, res.acc_x};
    assign o_m_axis_tuser = res.at_center;

endmodule
